// ===== src/lsu_pkg.sv =====
// Package: shared types and constants of the LMS step size update block.
`default_nettype none
package lsu_pkg;

    localparam int ENERGY_W = 31;
    localparam int STEP_W   = 16;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;
    localparam int SHIFT_W  = 5;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd1;

    localparam logic [CFG_W-1:0]   GAIN_RESET  = 15'd31129;
    localparam logic [CFG_W-1:0]   DECAY_RESET = 15'd32767;
    localparam logic [SHIFT_W-1:0] SHIFT_BIAS  = 5'd21;
    localparam logic [SHIFT_W-1:0] COARSE_SHIFT = 5'd8;
    localparam logic [SHIFT_W-1:0] FINE_SHIFT   = 5'd1;
    localparam logic [31:0]        ROUND_16    = 32'h0000_8000;
    localparam logic [STEP_W-1:0]  REPLACE_Q   = 16'd8192;
    localparam logic signed [31:0] GAIN_ROUND  = 32'sh0000_2000;
    localparam logic signed [31:0] DECAY_ROUND = 32'sh0000_4000;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                decay_en;
    } item_t;

    typedef struct packed {
        logic signed [STEP_W-1:0] step_size;
        logic                     recomputed;
        logic                     quotient_replaced;
    } result_t;

    typedef struct packed {
        logic load;
        logic norm_step;
        logic div_load;
        logic div_step;
        logic q_fix;
        logic mul_gain;
        logic mul_decay;
        logic step_gain;
        logic step_decay;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic recompute;
        logic norm_done;
        logic decay_req;
    } status_t;

endpackage
`default_nettype wire

// ===== src/lsu_datapath.sv =====
// Datapath: config registers, normalizer, restoring divider, shared multiplier, step register.
`default_nettype none
module lsu_datapath
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [lsu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsu_pkg::CFG_W-1:0]      cfg_data,
    input  wire lsu_pkg::item_t                 item,
    input  wire lsu_pkg::cmd_t                  cmd,
    output lsu_pkg::status_t                    status,
    output lsu_pkg::result_t                    result
);

    logic [lsu_pkg::CFG_W-1:0]    gain_reg;
    logic [lsu_pkg::CFG_W-1:0]    decay_reg;
    logic [lsu_pkg::ENERGY_W-1:0] n_reg;
    logic [lsu_pkg::SHIFT_W-1:0]  s_reg;
    logic                         recompute_reg;
    logic                         decay_en_reg;
    logic                         replaced_reg;
    logic [31:0]                  quo_reg;
    logic [15:0]                  rem_reg;
    logic [15:0]                  dmag_reg;
    logic                         q_neg_reg;
    logic [lsu_pkg::STEP_W-1:0]   q_reg;
    logic signed [31:0]           prod_reg;
    logic signed [lsu_pkg::STEP_W-1:0] step_reg;
    lsu_pkg::result_t             result_reg;

    logic [lsu_pkg::SHIFT_W-1:0]  e;
    logic [31:0]                  dsum;
    logic [15:0]                  d16;
    logic [16:0]                  rsh;
    logic [17:0]                  diff;
    logic                         ge;
    logic [lsu_pkg::STEP_W-1:0]   qs;
    logic signed [15:0]           mul_a;
    logic signed [15:0]           mul_b;
    logic signed [31:0]           rnd;
    logic [lsu_pkg::STEP_W-1:0]   rnd_q;

    // Divisor rounding and dividend exponent
    assign e    = s_reg + lsu_pkg::SHIFT_BIAS;
    assign dsum = {1'b0, n_reg} + lsu_pkg::ROUND_16;
    assign d16  = dsum[31:16];

    // One restoring divide step
    assign rsh  = {rem_reg, quo_reg[31]};
    assign diff = {1'b0, rsh} - {2'b00, dmag_reg};
    assign ge   = ~diff[17];

    assign qs = q_neg_reg ? (16'd0 - quo_reg[15:0]) : quo_reg[15:0];

    assign mul_a = cmd.mul_decay ? step_reg : $signed(q_reg);
    assign mul_b = cmd.mul_decay ? $signed({1'b0, decay_reg}) : $signed({1'b0, gain_reg});

    assign rnd   = prod_reg + (cmd.step_gain ? lsu_pkg::GAIN_ROUND : lsu_pkg::DECAY_ROUND);
    assign rnd_q = rnd[30:15];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= lsu_pkg::GAIN_RESET;
            decay_reg <= lsu_pkg::DECAY_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lsu_pkg::CFG_STEP_GAIN:    gain_reg  <= cfg_data;
                lsu_pkg::CFG_DECAY_FACTOR: decay_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= '0;
            recompute_reg   <= 1'b0;
            decay_en_reg    <= 1'b0;
            replaced_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                recompute_reg   <= (item.energy != '0);
                decay_en_reg    <= item.decay_en;
                replaced_reg    <= 1'b0;
            end
            if (cmd.q_fix)
            begin
                replaced_reg <= qs[15];
            end
            if (cmd.step_gain)
            begin
                step_reg <= $signed(16'd0 - rnd_q);
            end
            else if (cmd.step_decay)
            begin
                step_reg <= $signed(rnd_q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= item.energy;
            s_reg <= '0;
        end
        else if (cmd.norm_step)
        begin
            if (n_reg[30:23] == '0)
            begin
                n_reg <= {n_reg[22:0], 8'd0};
                s_reg <= s_reg + lsu_pkg::COARSE_SHIFT;
            end
            else
            begin
                n_reg <= {n_reg[29:0], 1'b0};
                s_reg <= s_reg + lsu_pkg::FINE_SHIFT;
            end
        end

        if (cmd.div_load)
        begin
            quo_reg   <= 32'd1 << e;
            rem_reg   <= '0;
            dmag_reg  <= d16;
            q_neg_reg <= (e == 5'd31) ^ d16[15];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[30:0], ge};
            rem_reg <= ge ? diff[15:0] : rsh[15:0];
        end

        if (cmd.q_fix)
        begin
            q_reg <= qs[15] ? lsu_pkg::REPLACE_Q : qs;
        end

        if (cmd.mul_gain || cmd.mul_decay)
        begin
            prod_reg <= mul_a * mul_b;
        end

        if (cmd.out_load)
        begin
            result_reg.step_size         <= step_reg;
            result_reg.recomputed        <= recompute_reg;
            result_reg.quotient_replaced <= replaced_reg;
        end
    end

    assign status.recompute = recompute_reg;
    assign status.norm_done = n_reg[30];
    assign status.decay_req = decay_en_reg;
    assign result           = result_reg;

endmodule
`default_nettype wire

// ===== src/lsu_ctrl.sv =====
// Controller: sequences normalize, divide, gain and decay steps and drives the handshakes.
`default_nettype none
module lsu_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    output logic                  result_valid,
    input  wire logic             result_ready,
    input  wire lsu_pkg::status_t status,
    output lsu_pkg::cmd_t         cmd
);

    typedef enum logic [8:0]
    {
        ST_IDLE  = 9'b000000001,
        ST_NORM  = 9'b000000010,
        ST_DIV   = 9'b000000100,
        ST_QFIX  = 9'b000001000,
        ST_MULG  = 9'b000010000,
        ST_STEPG = 9'b000100000,
        ST_MULD  = 9'b001000000,
        ST_STEPD = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [lsu_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [lsu_pkg::DIV_CNT_W-1:0]  cnt_next;
    logic                           result_valid_reg;
    logic                           result_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg & ~result_ready;
        cmd               = '0;
        item_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (!status.recompute)
                begin
                    state_next = status.decay_req ? ST_MULD : ST_DONE;
                end
                else if (status.norm_done)
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == lsu_pkg::DIV_CNT_W'(lsu_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_QFIX;
                end
            end
            ST_QFIX:
            begin
                cmd.q_fix  = 1'b1;
                state_next = ST_MULG;
            end
            ST_MULG:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_STEPG;
            end
            ST_STEPG:
            begin
                cmd.step_gain = 1'b1;
                state_next    = status.decay_req ? ST_MULD : ST_DONE;
            end
            ST_MULD:
            begin
                cmd.mul_decay = 1'b1;
                state_next    = ST_STEPD;
            end
            ST_STEPD:
            begin
                cmd.step_decay = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.out_load      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule
`default_nettype wire

// ===== src/lms_step_size_update_top.sv =====
// Top level: NLMS step size update, controller plus datapath.
// From input transfer to result valid: zero energy skips the recompute; a recompute runs
// the normalize steps, the restoring divider (one bit a cycle), the quotient fix and the
// gain multiply and step. Decay adds its multiply and step in both cases when requested.
// Items are handled one at a time; the next transfer is taken the cycle
// after the result is registered, while that result may still wait on result_ready.
// Reset (rst_n low, asynchronous): step size 0, step_gain 31129, decay_factor 32767, idle.
`default_nettype none
module lms_step_size_update_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire lsu_pkg::item_t                item,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output lsu_pkg::result_t                   result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lsu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lsu_pkg::CFG_W-1:0]     cfg_data
);

    lsu_pkg::cmd_t    cmd;
    lsu_pkg::status_t status;

    assign cfg_ready = 1'b1;

    lsu_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    lsu_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
`default_nettype wire

// ===== src/lsu_checker.sv =====
// Port checker for the step size update block, bound to the top level.
`default_nettype none
module lsu_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_ready,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire lsu_pkg::result_t              result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result dropped or changed while stalled");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while previous one still in work");

    a_replaced_needs_recompute: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.recomputed |-> !result.quotient_replaced)
        else $error("quotient replaced without recompute");

    a_recompute_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.recomputed |->
            result.step_size[15] || (result.step_size == '0))
        else $error("recomputed step size is positive");

endmodule

bind lms_step_size_update_top lsu_checker u_lsu_checker (.*);
`default_nettype wire

// ===== sim/tb_lms_step_size_update_top.sv =====
// Testbench for lms_step_size_update_top: random and directed items checked against a predictor.
`default_nettype none
module tb_lms_step_size_update_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_REPORTS = 10;
    localparam logic [lsu_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic [lsu_pkg::ENERGY_W-1:0] DIRECTED_E [20] = '{
        31'h4000_0000, 31'h0000_0000, 31'h0000_0000, 31'h7FFF_FFFF,
        31'h7FFF_8000, 31'h7FFF_7FFF, 31'h0000_0001, 31'h0010_0000,
        31'h001F_FFFF, 31'h0018_0000, 31'h0020_0000, 31'h5555_5555,
        31'h2AAA_AAAA, 31'h0000_0000, 31'h0000_FFFF, 31'h3FFF_FFFF,
        31'h0000_0003, 31'h0000_0000, 31'h0800_0000, 31'h1234_5678
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    lsu_pkg::item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    lsu_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [lsu_pkg::CFG_IDX_W-1:0] cfg_index = lsu_pkg::CFG_STEP_GAIN;
    logic [lsu_pkg::CFG_W-1:0] cfg_data = '0;

    lsu_pkg::item_t pending_items [$];
    lsu_pkg::result_t expected_steps [$];
    logic signed [lsu_pkg::STEP_W-1:0] model_step = '0;
    logic [lsu_pkg::CFG_W-1:0] model_gain = lsu_pkg::GAIN_RESET;
    logic [lsu_pkg::CFG_W-1:0] model_decay = lsu_pkg::DECAY_RESET;

    logic idle_on = 1'b1;
    logic hold_armed = 1'b0;
    logic rx_hold = 1'b0;
    int unsigned send_gap = 0;
    int unsigned rx_wait = 0;
    int unsigned n_items = 0;
    int unsigned n_results = 0;
    int unsigned n_mismatch = 0;
    int unsigned n_settings = 1;

    lms_step_size_update_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic lsu_pkg::result_t predict_step(
        input lsu_pkg::item_t it,
        input logic signed [lsu_pkg::STEP_W-1:0] cur,
        input logic [lsu_pkg::CFG_W-1:0] gain,
        input logic [lsu_pkg::CFG_W-1:0] decay);
        logic [31:0] norm;
        logic [31:0] rounded;
        logic [lsu_pkg::SHIFT_W-1:0] shifts;
        logic [lsu_pkg::SHIFT_W-1:0] expo;
        logic signed [lsu_pkg::STEP_W-1:0] divisor;
        logic signed [lsu_pkg::STEP_W-1:0] recip;
        logic signed [lsu_pkg::STEP_W-1:0] stp;
        longint numer;
        longint quo;
        int prod;
        lsu_pkg::result_t r;
        r = '0;
        stp = cur;
        if (it.energy != '0)
        begin
            norm = {1'b0, it.energy};
            shifts = '0;
            while (!norm[30])
            begin
                norm = norm << 1;
                shifts = shifts + 1'b1;
            end
            rounded = norm + lsu_pkg::ROUND_16;
            divisor = rounded[31:16];
            expo = shifts + lsu_pkg::SHIFT_BIAS;
            numer = (expo == 5'd31) ? -64'sd2147483648 : (64'sd1 << expo);
            quo = numer / longint'(divisor);
            recip = quo[15:0];
            if (recip < 0)
            begin
                recip = lsu_pkg::REPLACE_Q;
                r.quotient_replaced = 1'b1;
            end
            prod = int'(recip) * int'({17'd0, gain}) + lsu_pkg::GAIN_ROUND;
            stp = 16'(-(prod >>> 15));
            r.recomputed = 1'b1;
        end
        if (it.decay_en)
        begin
            prod = int'(stp) * int'({17'd0, decay}) + lsu_pkg::DECAY_ROUND;
            stp = 16'(prod >>> 15);
        end
        r.step_size = stp;
        return r;
    endfunction

    task automatic write_reg(input logic [lsu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lsu_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait until every item is sent and every result has come back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || item_valid || expected_steps.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // item driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || item_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
                send_gap <= idle_on ? $urandom_range(0, 7) : 0;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge clk)
    begin : receiver
        int unsigned w;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            rx_wait <= 0;
        end
        else if (rx_hold)
        begin
            result_ready <= 1'b0;
        end
        else if (result_valid && result_ready)
        begin
            w = idle_on ? $urandom_range(0, 7) : 0;
            if (w == 0)
            begin
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= 1'b0;
                rx_wait <= w - 1;
            end
        end
        else if (!result_ready)
        begin
            if (rx_wait > 0)
                rx_wait <= rx_wait - 1;
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin : receiver_hold
        wait (hold_armed);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // monitor: register writes, item transfers, result checks
    always @(posedge clk)
    begin : monitor
        lsu_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == lsu_pkg::CFG_STEP_GAIN)
                    model_gain = cfg_data;
                else if (cfg_index == lsu_pkg::CFG_DECAY_FACTOR)
                    model_decay = cfg_data;
            end
            if (result_valid && result_ready)
            begin
                n_results++;
                if (expected_steps.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("%0t: unexpected result transfer step=%0d", $realtime,
                                 result.step_size);
                end
                else
                begin
                    want = expected_steps.pop_front();
                    if (result !== want)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS)
                            $display({"%0t: result %0d mismatch: step %0d/%0d ",
                                      "recomp %b/%b repl %b/%b (exp/act)"},
                                     $realtime, n_results, want.step_size, result.step_size,
                                     want.recomputed, result.recomputed,
                                     want.quotient_replaced, result.quotient_replaced);
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                n_items++;
                want = predict_step(item, model_step, model_gain, model_decay);
                model_step = want.step_size;
                expected_steps.push_back(want);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("tb_lms_step_size_update_top failed");
        $finish;
    end

    initial
    begin : stimulus
        lsu_pkg::item_t it;
        int unsigned sel;
        int unsigned k;
        logic [31:0] mask;
        logic [lsu_pkg::CFG_W-1:0] gain_v;
        logic [lsu_pkg::CFG_W-1:0] decay_v;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        foreach (DIRECTED_E[i])
        begin
            it.energy = DIRECTED_E[i];
            it.decay_en = i[0];
            pending_items.push_back(it);
        end
        drain();
        write_reg(CFG_UNUSED_IDX, lsu_pkg::CFG_W'($urandom));

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin gain_v = '0; decay_v = '0; end
                1: begin gain_v = 15'h7FFF; decay_v = 15'h7FFF; end
                4: begin gain_v = 15'd1; decay_v = 15'd1; end
                default:
                begin
                    gain_v = $urandom_range(0, 32767);
                    decay_v = $urandom_range(0, 32767);
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(lsu_pkg::CFG_STEP_GAIN, gain_v);
                write_reg(lsu_pkg::CFG_DECAY_FACTOR, decay_v);
            end
            else
            begin
                write_reg(lsu_pkg::CFG_DECAY_FACTOR, decay_v);
                write_reg(lsu_pkg::CFG_STEP_GAIN, gain_v);
            end
            n_settings++;

            @(negedge clk);
            idle_on = (p != 2);
            if (p == 3)
                hold_armed = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 15);
                if (sel == 0)
                    it.energy = '0;
                else if (sel == 1)
                    it.energy = DIRECTED_E[$urandom_range(0, 19)];
                else if (sel == 2)
                    it.energy = 31'(32'h7FFF_0000 + $urandom_range(0, 32'hFFFF));
                else
                begin
                    k = $urandom_range(1, 31);
                    mask = (32'h1 << k) - 1;
                    it.energy = 31'(($urandom & mask) | (32'h1 << (k - 1)));
                end
                it.decay_en = $urandom_range(0, 1);
                pending_items.push_back(it);
            end
            drain();
        end

        $display("Ran %0d items over %0d register settings (zero and full gain/decay included),",
                 n_items, n_settings);
        $display("checked %0d results, %0d mismatches.", n_results, n_mismatch);
        if (n_mismatch == 0 && expected_steps.size() == 0)
            $display("tb_lms_step_size_update_top passed");
        else
            $display("tb_lms_step_size_update_top failed");
        $finish;
    end

endmodule
`default_nettype wire
